>>> rtl/rgb2nv12_pkg.sv
// ----------------------------------------------------------------------------
// rgb2nv12_pkg
// Shared sizes, coefficients and helpers of the RGB to NV12 converter.
// ----------------------------------------------------------------------------
package rgb2nv12_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;

  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W   = $clog2(MAX_HEIGHT);
  localparam int unsigned LINE_AW = $clog2(LINE_DEPTH);
  localparam int unsigned PAIR_W  = 9;
  localparam int unsigned LINE_W  = 3 * PAIR_W;
  localparam int unsigned YIDX_W  = 24;
  localparam int unsigned UVIDX_W = 23;
  localparam int unsigned ADDR_W  = 3;

  localparam logic [SIZE_W-1:0] MAX_W_SIZE   = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_H_SIZE   = SIZE_W'(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [17:0] Y_R   = 18'd263;
  localparam logic [17:0] Y_G   = 18'd516;
  localparam logic [17:0] Y_B   = 18'd100;
  localparam logic [7:0]  Y_OFS = 8'd16;

  localparam logic [18:0] U_R   = 19'd152;
  localparam logic [18:0] U_G   = 19'd298;
  localparam logic [18:0] U_B   = 19'd450;
  localparam logic [18:0] V_R   = 19'd450;
  localparam logic [18:0] V_G   = 19'd377;
  localparam logic [18:0] V_B   = 19'd73;
  localparam logic [18:0] C_OFS = 19'd131072;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_e;

  function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] raw,
                                                 logic [SIZE_W-1:0] max_v);
    logic [SIZE_W-1:0] v;
    v = {raw[SIZE_W-1:1], 1'b0};
    if (v < SIZE_W'(2)) begin
      v = SIZE_W'(2);
    end
    if (v > max_v) begin
      v = max_v;
    end
    return v;
  endfunction

endpackage

>>> rtl/rgba_to_nv12_converter_top.sv
// ----------------------------------------------------------------------------
// rgba_to_nv12_converter_top
// Streaming RGB to NV12 converter with BT.601 studio-range coefficients.
// ----------------------------------------------------------------------------
// Pixels enter on the s_axis channel in raster order, one item per pixel.
// Each pixel leaves on the m_axis channel as one item with its luma byte and
// Y plane offset. On odd rows at odd columns the item also carries Cb, Cr
// and the U offset of the 2x2 block that ends there, flagged in tuser, and
// tlast marks the final pixel of the frame.
// Frame width and height are set through the APB port at byte addresses 0
// and 4, by the user only while the stream is idle; the block itself does not
// enforce this. Odd values are rounded down to even and clamped to 2..4096.
// An item is accepted in every cycle unless a receiver stall has filled the
// pipeline; it passes the stage 1, 2 and 3 and output registers in turn.
// The line store, a single 2048 x 27 memory, is written once per pixel pair
// on even rows and read once per pair on odd rows, one access per cycle.
// Reset clears the row and column counters and the pipeline; the line store
// needs no clearing because every entry is written on an even row before it
// is read on the odd row after it.
// When the receiver stalls, the four pipeline stages fill up and tready on
// the input drops only once all of them hold an item.
// ----------------------------------------------------------------------------
module rgba_to_nv12_converter_top
  import rgb2nv12_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  logic [23:0]        s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // y_value [7:0], y_index [31:8], u_value [39:32], v_value [47:40],
  // uv_index [70:48], zero [71]
  output logic [71:0]        m_axis_tdata,
  // chroma_valid [0]
  output logic               m_axis_tuser,
  output logic               m_axis_tlast
);

  logic [SIZE_W-1:0] width_q, height_q;
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic              cfg_we;
  reg_index_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_index_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, width_q};
      REG_FRAME_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, height_q};
      default:          prdata = '0;
    endcase
  end

  assign w_eff = eff_size(width_q, MAX_W_SIZE);
  assign h_eff = eff_size(height_q, MAX_H_SIZE);

  // Pipeline flow control.
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  logic in_acc;

  assign en4           = !v4_q || m_axis_tready;
  assign en3           = !v3_q || en4;
  assign en2           = !v2_q || en3;
  assign en1           = !v1_q || en2;
  assign s_axis_tready = en1;
  assign in_acc        = s_axis_tvalid && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Accept stage: counters, left pixel and line store access.
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [23:0]       left_q;
  logic [7:0]        in_r, in_g, in_b;
  logic [PAIR_W-1:0] sr, sg, sb;
  logic              row_end, frame_end, odd_col, odd_row;
  logic [LINE_AW-1:0] slot;
  logic              mem_we, mem_re;

  assign in_r      = s_axis_tdata[7:0];
  assign in_g      = s_axis_tdata[15:8];
  assign in_b      = s_axis_tdata[23:16];
  assign odd_col   = col_q[0];
  assign odd_row   = row_q[0];
  assign slot      = col_q[COL_W-1:1];
  assign row_end   = ({1'b0, col_q} + SIZE_W'(1)) >= w_eff;
  assign frame_end = row_end && (({1'b0, row_q} + SIZE_W'(1)) >= h_eff);
  assign sr        = {1'b0, left_q[7:0]}   + {1'b0, in_r};
  assign sg        = {1'b0, left_q[15:8]}  + {1'b0, in_g};
  assign sb        = {1'b0, left_q[23:16]} + {1'b0, in_b};
  assign mem_we    = in_acc && odd_col && !odd_row;
  assign mem_re    = in_acc && odd_col && odd_row;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (row_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : row_q + ROW_W'(1);
    end else begin
      col_d = col_q + COL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
      if (!odd_col) begin
        left_q <= s_axis_tdata;
      end
    end
  end

  logic [LINE_W-1:0] line_mem [LINE_DEPTH];
  logic [LINE_W-1:0] line_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[slot] <= {sb, sg, sr};
    end
    if (mem_re) begin
      line_rd_q <= line_mem[slot];
    end
  end

  // Stage 1: luma sum, Y row product and block averages.
  logic [7:0]        r1_q, g1_q, b1_q;
  logic [PAIR_W-1:0] sr1_q, sg1_q, sb1_q;
  logic [COL_W-1:0]  col1_q;
  logic [ROW_W-1:0]  row1_q;
  logic [SIZE_W-1:0] w1_q;
  logic              chr1_q, last1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      r1_q    <= in_r;
      g1_q    <= in_g;
      b1_q    <= in_b;
      sr1_q   <= sr;
      sg1_q   <= sg;
      sb1_q   <= sb;
      col1_q  <= col_q;
      row1_q  <= row_q;
      w1_q    <= w_eff;
      chr1_q  <= odd_col && odd_row;
      last1_q <= frame_end;
    end
  end

  logic [17:0]             ysum;
  logic [ROW_W+SIZE_W-1:0] yprod;
  logic [PAIR_W:0]         qr, qg, qb;

  assign ysum  = Y_R * {10'd0, r1_q} + Y_G * {10'd0, g1_q} + Y_B * {10'd0, b1_q};
  assign yprod = {{SIZE_W{1'b0}}, row1_q} * {{ROW_W{1'b0}}, w1_q};
  assign qr    = {1'b0, sr1_q} + {1'b0, line_rd_q[PAIR_W-1:0]};
  assign qg    = {1'b0, sg1_q} + {1'b0, line_rd_q[2*PAIR_W-1:PAIR_W]};
  assign qb    = {1'b0, sb1_q} + {1'b0, line_rd_q[3*PAIR_W-1:2*PAIR_W]};

  logic [7:0]        yv2_q, ar2_q, ag2_q, ab2_q;
  logic [YIDX_W-1:0] yprod2_q;
  logic [COL_W-1:0]  col2_q;
  logic [ROW_W-2:0]  hrow2_q;
  logic [SIZE_W-1:0] w2_q;
  logic              chr2_q, last2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      yv2_q    <= ysum[17:10] + Y_OFS;
      yprod2_q <= yprod[YIDX_W-1:0];
      ar2_q    <= qr[PAIR_W:2];
      ag2_q    <= qg[PAIR_W:2];
      ab2_q    <= qb[PAIR_W:2];
      col2_q   <= col1_q;
      hrow2_q  <= row1_q[ROW_W-1:1];
      w2_q     <= w1_q;
      chr2_q   <= chr1_q;
      last2_q  <= last1_q;
    end
  end

  // Stage 2: Y offset, UV row product and chroma sums.
  logic [ROW_W+SIZE_W-2:0] uvprod;
  logic [18:0]             su, sv;

  assign uvprod = {{SIZE_W{1'b0}}, hrow2_q} * {{(ROW_W-1){1'b0}}, w2_q};
  assign su = (U_B * {11'd0, ab2_q} + C_OFS) - (U_R * {11'd0, ar2_q} + U_G * {11'd0, ag2_q});
  assign sv = (V_R * {11'd0, ar2_q} + C_OFS) - (V_G * {11'd0, ag2_q} + V_B * {11'd0, ab2_q});

  logic [7:0]         yv3_q, u3_q, v3v_q;
  logic [YIDX_W-1:0]  yidx3_q;
  logic [UVIDX_W-1:0] uvprod3_q;
  logic [COL_W-1:0]   col3_q;
  logic               chr3_q, last3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      yv3_q     <= yv2_q;
      yidx3_q   <= yprod2_q + {{(YIDX_W-COL_W){1'b0}}, col2_q};
      u3_q      <= su[17:10];
      v3v_q     <= sv[17:10];
      uvprod3_q <= uvprod[UVIDX_W-1:0];
      col3_q    <= col2_q;
      chr3_q    <= chr2_q;
      last3_q   <= last2_q;
    end
  end

  // Stage 3: UV offset and output register.
  logic [UVIDX_W-1:0] uvidx;

  assign uvidx = uvprod3_q + {{(UVIDX_W-COL_W){1'b0}}, col3_q} - UVIDX_W'(1);

  logic [7:0]         yv4_q, u4_q, v4v_q;
  logic [YIDX_W-1:0]  yidx4_q;
  logic [UVIDX_W-1:0] uvidx4_q;
  logic               chr4_q, last4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      yv4_q    <= yv3_q;
      yidx4_q  <= yidx3_q;
      u4_q     <= chr3_q ? u3_q : 8'd0;
      v4v_q    <= chr3_q ? v3v_q : 8'd0;
      uvidx4_q <= chr3_q ? uvidx : '0;
      chr4_q   <= chr3_q;
      last4_q  <= last3_q;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {1'b0, uvidx4_q, v4v_q, u4_q, yidx4_q, yv4_q};
  assign m_axis_tuser  = chr4_q;
  assign m_axis_tlast  = last4_q;

  // The line store takes one access per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("Line store written and read in the same cycle.");

  // The final pixel of a frame returns both counters to the origin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && frame_end) |=> (col_q == '0 && row_q == '0))
    else $error("Counters did not wrap at the end of the frame.");

  // Inside a row the column advances by one per item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !row_end) |=> (col_q == $past(col_q) + COL_W'(1) && row_q == $past(row_q)))
    else $error("Column counter did not advance inside the row.");

  // An empty first stage always takes a new item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> s_axis_tready)
    else $error("Input stalled while the first stage is empty.");

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming RGB to NV12 converter.
// ----------------------------------------------------------------------------
// A short table of pixels and size writes runs first. It covers the reset
// sizes, pure-color 2x2 frames with known luma and chroma, and a width change
// in the middle of a frame. Random phases follow, often with new frame sizes:
// odd and out-of-range values, the largest sizes, and frames that stop short.
// Every accepted pixel is run through a bit-accurate converter model. Each
// output item is compared field by field with the oldest prediction. Both
// stream sides pause at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgb2nv12_pkg::*;

  localparam int LU_R   = 263;
  localparam int LU_G   = 516;
  localparam int LU_B   = 100;
  localparam int LU_OFS = 16;
  localparam int CB_R   = -152;
  localparam int CB_G   = -298;
  localparam int CB_B   = 450;
  localparam int CR_R   = 450;
  localparam int CR_G   = -377;
  localparam int CR_B   = -73;
  localparam int C_BIAS = 131072;
  localparam int unsigned RANDOM_PIXELS = 1200;

  typedef struct packed {
    logic [7:0]  y_value;
    logic [23:0] y_index;
    logic        chroma_valid;
    logic [7:0]  u_value;
    logic [7:0]  v_value;
    logic [22:0] uv_index;
    logic        frame_last;
  } nv12_px_t;

  typedef enum logic [1:0] {
    STEP_WRITE,
    STEP_PIXEL,
    STEP_PIXEL_KNOWN
  } step_kind_e;

  typedef struct {
    step_kind_e  kind;
    reg_index_e  target;
    logic [31:0] value;
    logic [23:0] rgb;
    nv12_px_t    known;
  } step_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // red [7:0], green [15:8], blue [23:16]
  logic [23:0]       s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // y_value [7:0], y_index [31:8], u_value [39:32], v_value [47:40],
  // uv_index [70:48], zero [71]
  logic [71:0]       m_axis_tdata;
  // chroma_valid [0]
  logic              m_axis_tuser;
  logic              m_axis_tlast;

  logic [12:0]  width_raw = WIDTH_RESET;
  logic [12:0]  height_raw = HEIGHT_RESET;
  int unsigned  col_cnt = 0;
  int unsigned  row_cnt = 0;
  logic [23:0]  left_rgb = '0;
  bit [26:0]    line_sums [LINE_DEPTH];
  bit           line_seen [LINE_DEPTH];

  nv12_px_t     queued_nv12 [$];
  int unsigned  mismatches = 0;
  int unsigned  results_seen = 0;
  int unsigned  frames_seen = 0;
  int unsigned  chroma_seen = 0;
  int unsigned  pixels_sent = 0;
  int unsigned  writes_done = 0;
  int unsigned  widest = 0;
  int unsigned  tallest = 0;
  int unsigned  stall_left = 0;
  bit           steady = 1'b0;

  rgba_to_nv12_converter_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned clamp_size(logic [12:0] raw, int unsigned max_v);
    int unsigned v;
    v = raw & 13'h1FFE;
    if (v < 2) begin
      v = 2;
    end
    if (v > max_v) begin
      v = max_v;
    end
    return v;
  endfunction

  function automatic nv12_px_t convert_pixel(logic [23:0] rgb);
    int unsigned w, h, r, g, b, col, row, slot, sr, sg, sb;
    int          ar, ag, ab, cu, cv;
    bit          row_end, frame_end;
    bit [26:0]   upper;
    nv12_px_t    px;
    r = rgb[7:0];
    g = rgb[15:8];
    b = rgb[23:16];
    w = clamp_size(width_raw, MAX_WIDTH);
    h = clamp_size(height_raw, MAX_HEIGHT);
    col = col_cnt;
    row = row_cnt;
    slot = (col >> 1) % LINE_DEPTH;
    row_end = (col + 1 >= w);
    frame_end = row_end && (row + 1 >= h);
    px = '0;
    px.y_value = 8'(((LU_R * r + LU_G * g + LU_B * b) >> 10) + LU_OFS);
    px.y_index = 24'(row * w + col);
    if ((col & 1) == 0) begin
      left_rgb = rgb;
    end else begin
      sr = left_rgb[7:0] + r;
      sg = left_rgb[15:8] + g;
      sb = left_rgb[23:16] + b;
      if ((row & 1) == 0) begin
        line_sums[slot] = {9'(sb), 9'(sg), 9'(sr)};
        line_seen[slot] = 1'b1;
      end else begin
        upper = line_sums[slot];
        ar = int'((sr + upper[8:0]) >> 2);
        ag = int'((sg + upper[17:9]) >> 2);
        ab = int'((sb + upper[26:18]) >> 2);
        cu = CB_R * ar + CB_G * ag + CB_B * ab + C_BIAS;
        cv = CR_R * ar + CR_G * ag + CR_B * ab + C_BIAS;
        px.chroma_valid = 1'b1;
        px.u_value = 8'(cu >>> 10);
        px.v_value = 8'(cv >>> 10);
        px.uv_index = 23'((row >> 1) * w + col - 1);
      end
    end
    if (row_end) begin
      col_cnt = 0;
      row_cnt = frame_end ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
    end
    px.frame_last = frame_end;
    return px;
  endfunction

  // An odd row may only go on to slots that some even row has filled.
  function automatic bit line_ready(int unsigned w);
    for (int unsigned s = col_cnt >> 1; s < w / 2; s++) begin
      if (!line_seen[s]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic nv12_px_t known_px(int unsigned y, int unsigned idx, bit blk_end,
                                        int unsigned u, int unsigned v);
    nv12_px_t px;
    px = '0;
    px.y_value = 8'(y);
    px.y_index = 24'(idx);
    px.frame_last = blk_end;
    if (blk_end) begin
      px.chroma_valid = 1'b1;
      px.u_value = 8'(u);
      px.v_value = 8'(v);
    end
    return px;
  endfunction

  function automatic step_t pixel_step(logic [23:0] rgb);
    step_t s;
    s = '{STEP_PIXEL, REG_FRAME_WIDTH, '0, rgb, '0};
    return s;
  endfunction

  function automatic step_t known_step(logic [23:0] rgb, nv12_px_t px);
    step_t s;
    s = '{STEP_PIXEL_KNOWN, REG_FRAME_WIDTH, '0, rgb, px};
    return s;
  endfunction

  function automatic step_t write_step(reg_index_e target, logic [31:0] value);
    step_t s;
    s = '{STEP_WRITE, target, value, '0, '0};
    return s;
  endfunction

  function automatic int unsigned pause_len();
    if ($urandom_range(0, 99) < 80) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned gap_len();
    if (steady || $urandom_range(0, 99) < 55) begin
      return 0;
    end
    return pause_len();
  endfunction

  function automatic logic [7:0] channel();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 10) begin
      return 8'd0;
    end
    if (p < 20) begin
      return 8'd255;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [12:0] pick_size();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 68) begin
      return 13'($urandom_range(2, 12));
    end
    if (p < 76) begin
      return 13'($urandom_range(0, 1));
    end
    if (p < 86) begin
      return 13'($urandom_range(13, 64));
    end
    if (p < 90) begin
      return 13'd4096;
    end
    if (p < 95) begin
      return ($urandom_range(0, 1) != 0) ? 13'd8191 : 13'($urandom_range(4097, 8190));
    end
    return 13'($urandom_range(0, 8191));
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 30) begin
      $display("MISMATCH at output item %0d, %s: got 0x%0h, expected 0x%0h",
               results_seen, field, got, want);
    end
  endtask

  task automatic write_reg(reg_index_e target, logic [31:0] value);
    int unsigned eff;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(target));
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (target == REG_FRAME_WIDTH) begin
      width_raw = value[12:0];
      eff = clamp_size(width_raw, MAX_WIDTH);
      if (eff > widest) begin
        widest = eff;
      end
    end else begin
      height_raw = value[12:0];
      eff = clamp_size(height_raw, MAX_HEIGHT);
      if (eff > tallest) begin
        tallest = eff;
      end
    end
    writes_done++;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_pixel(logic [23:0] rgb, int unsigned gap, bit use_known,
                            nv12_px_t known);
    nv12_px_t px;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= rgb;
    do @(posedge clk_i); while (!s_axis_tready);
    px = convert_pixel(rgb);
    if (use_known) begin
      px = known;
    end
    queued_nv12.push_back(px);
    pixels_sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (queued_nv12.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 12) begin
      stall_left = pause_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : watch
    nv12_px_t got;
    nv12_px_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.y_value = m_axis_tdata[7:0];
      got.y_index = m_axis_tdata[31:8];
      got.u_value = m_axis_tdata[39:32];
      got.v_value = m_axis_tdata[47:40];
      got.uv_index = m_axis_tdata[70:48];
      got.chroma_valid = m_axis_tuser;
      got.frame_last = m_axis_tlast;
      if (queued_nv12.size() == 0) begin
        flag_mismatch("item with no pixel pending", 32'(got.y_index), '0);
      end else begin
        want = queued_nv12.pop_front();
        if (got.y_value !== want.y_value) begin
          flag_mismatch("y_value", 32'(got.y_value), 32'(want.y_value));
        end
        if (got.y_index !== want.y_index) begin
          flag_mismatch("y_index", 32'(got.y_index), 32'(want.y_index));
        end
        if (got.chroma_valid !== want.chroma_valid) begin
          flag_mismatch("chroma_valid", 32'(got.chroma_valid), 32'(want.chroma_valid));
        end
        if (got.u_value !== want.u_value) begin
          flag_mismatch("u_value", 32'(got.u_value), 32'(want.u_value));
        end
        if (got.v_value !== want.v_value) begin
          flag_mismatch("v_value", 32'(got.v_value), 32'(want.v_value));
        end
        if (got.uv_index !== want.uv_index) begin
          flag_mismatch("uv_index", 32'(got.uv_index), 32'(want.uv_index));
        end
        if (got.frame_last !== want.frame_last) begin
          flag_mismatch("frame_last", 32'(got.frame_last), 32'(want.frame_last));
        end
      end
      results_seen++;
      if (got.frame_last === 1'b1) begin
        frames_seen++;
      end
      if (got.chroma_valid === 1'b1) begin
        chroma_seen++;
      end
    end
  end

  initial begin : stimulus
    step_t        plan [$];
    logic [23:0]  hue [4];
    int unsigned  hue_y [4];
    int unsigned  hue_u [4];
    int unsigned  hue_v [4];
    int unsigned  random_sent;
    int unsigned  phases;
    int unsigned  w, h, rem, count;
    logic [12:0]  raw;
    logic [31:0]  value;
    hue = '{24'hFFFFFF, 24'hFF0000, 24'h0000FF, 24'h00FF00};
    hue_y = '{234, 40, 81, 144};
    hue_u = '{128, 240, 90, 53};
    hue_v = '{128, 109, 240, 34};
    random_sent = 0;
    phases = 0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    plan.push_back(known_step(24'h000000, known_px(16, 0, 1'b0, 0, 0)));
    plan.push_back(known_step(24'hFFFFFF, known_px(234, 1, 1'b0, 0, 0)));
    plan.push_back(write_step(REG_FRAME_WIDTH, 32'd2));
    plan.push_back(write_step(REG_FRAME_HEIGHT, 32'd2));
    plan.push_back(pixel_step(24'h0000FF));
    plan.push_back(pixel_step(24'h00FF00));
    plan.push_back(pixel_step(24'hFF0000));
    for (int k = 0; k < 4; k++) begin
      for (int p = 0; p < 4; p++) begin
        plan.push_back(known_step(hue[k],
                                  known_px(hue_y[k], p, p == 3, hue_u[k], hue_v[k])));
      end
    end

    foreach (plan[i]) begin
      case (plan[i].kind)
        STEP_WRITE: begin
          settle();
          write_reg(plan[i].target, plan[i].value);
        end
        STEP_PIXEL: begin
          send_pixel(plan[i].rgb, gap_len(), 1'b0, '0);
        end
        default: begin
          send_pixel(plan[i].rgb, gap_len(), 1'b1, plan[i].known);
        end
      endcase
    end

    while (random_sent < RANDOM_PIXELS) begin
      settle();
      phases++;
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) begin
        raw = pick_size();
        if (((row_cnt & 1) == 0) || line_ready(clamp_size(raw, MAX_WIDTH))) begin
          value = $urandom();
          value[12:0] = raw;
          write_reg(REG_FRAME_WIDTH, value);
        end
      end
      if ($urandom_range(0, 9) < 7) begin
        value = $urandom();
        value[12:0] = pick_size();
        write_reg(REG_FRAME_HEIGHT, value);
      end
      w = clamp_size(width_raw, MAX_WIDTH);
      h = clamp_size(height_raw, MAX_HEIGHT);
      rem = (col_cnt + 1 >= w) ? 1 : w - col_cnt;
      if (row_cnt + 1 < h) begin
        rem += (h - row_cnt - 1) * w;
      end
      if (w * h <= 256 && rem <= 512) begin
        count = rem + w * h * $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) begin
          count = $urandom_range(1, rem);
        end
      end else begin
        count = $urandom_range(1, 120);
      end
      repeat (count) begin
        send_pixel({channel(), channel(), channel()}, gap_len(), 1'b0, '0);
        random_sent++;
      end
    end

    settle();
    $display("Converted %0d pixels in %0d random phases after the directed table;",
             pixels_sent, phases);
    $display("%0d frames closed, %0d items with chroma, %0d size writes, up to %0d x %0d.",
             frames_seen, chroma_seen, writes_done, widest, tallest);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rgb2nv12_pkg.sv
rtl/rgba_to_nv12_converter_top.sv
bench/tb.sv
